// File: design/pidl_pkg.sv
// shared types and codes for the positional insert/delete list
package pidl_pkg;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_PRIOR  = 3'd4,
        ACT_NEXT   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         position;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [6:0]         count;
    } rsp_t;

    // per-transaction control broadcast to every cell
    typedef struct packed {
        logic       ins;
        logic       del;
        logic       rd;
        logic [6:0] idx;
    } cell_ctl_t;

endpackage

// File: design/positional_insert_delete_list.sv
// Ordered list of signed 32-bit values, positions from 1, held in a row of cells that each
// keep one entry and shift to a neighbor on insert or delete. A command is taken when start
// is high and busy is low; the accept cycle decodes it, shifts the cells and latches the
// addressed cell's tap, and in the next cycle the OR of all cell taps forms the result, shown
// with done for exactly that cycle while busy is high. The receiver cannot stall, so each
// result must be taken when done is high.
module positional_insert_delete_list #(
    parameter int CAPACITY = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pidl_pkg::cmd_t command,
    output logic           done,
    output pidl_pkg::rsp_t result
);
    import pidl_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int PW      = ((COUNT_W > 7) ? COUNT_W : 7) + 1;
    localparam int IW      = $clog2(CAPACITY);

    logic               accept;
    logic               busy_reg;
    logic               busy_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    cell_ctl_t          ctl;
    logic [PW-1:0]      p;
    logic [PW-1:0]      c;
    logic signed [31:0] ent [CAPACITY];
    logic signed [31:0] tap [CAPACITY];
    logic signed [31:0] rd_data;

    assign accept = start && !busy_reg;
    assign p      = PW'(command.position);
    assign c      = PW'(cnt_reg);

    always_comb
    begin
        status_next = ST_BADPOS;
        cnt_next    = cnt_reg;
        ctl         = '0;
        unique case (command.action)
            ACT_READ:
            begin
                ctl.idx = command.position - 7'd1;
                if (p >= PW'(1) && p <= c)
                begin
                    status_next = ST_OK;
                    ctl.rd      = accept;
                end
            end
            ACT_INSERT:
            begin
                ctl.idx = command.position - 7'd1;
                if (p < PW'(1) || p > c + PW'(1))
                    status_next = ST_BADPOS;
                else if (c == PW'(CAPACITY))
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_OK;
                    ctl.ins     = accept;
                    cnt_next    = cnt_reg + COUNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                ctl.idx = command.position - 7'd1;
                if (p >= PW'(1) && p <= c)
                begin
                    status_next = ST_OK;
                    ctl.del     = accept;
                    cnt_next    = cnt_reg - COUNT_W'(1);
                end
            end
            ACT_CLEAR:
            begin
                status_next = ST_OK;
                cnt_next    = '0;
            end
            ACT_PRIOR:
            begin
                ctl.idx = command.position - 7'd2;
                if (p >= PW'(2) && p <= c)
                begin
                    status_next = ST_OK;
                    ctl.rd      = accept;
                end
            end
            ACT_NEXT:
            begin
                ctl.idx = command.position;
                if (p >= PW'(1) && p < c)
                begin
                    status_next = ST_OK;
                    ctl.rd      = accept;
                end
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    assign busy_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            status_reg <= status_next;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left;
        logic signed [31:0] right;

        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_mid_l
            assign left = ent[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid_r
            assign right = ent[i+1];
        end

        pidl_cell #(
            .IDX (i),
            .W   (PW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .ins_value (command.value),
            .left      (left),
            .right     (right),
            .entry     (ent[i]),
            .tap       (tap[i])
        );
    end

    // only the addressed cell has a nonzero tap
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_data = rd_data | tap[IW'(i)];
    end

    assign busy          = busy_reg;
    assign done          = busy_reg;
    assign result.status = status_reg;
    assign result.data   = rd_data;
    assign result.count  = 7'(c);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("accepted transaction gave no result");

    a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result held for more than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> c <= PW'(CAPACITY))
        else $error("count exceeds capacity");

    a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.data == '0)
        else $error("nonzero data on failed transaction");

endmodule

// File: design/pidl_cell.sv
// one list entry: shifts with its neighbors on insert/delete, taps itself out on a read
module pidl_cell #(
    parameter int IDX = 0,
    parameter int W   = 8
) (
    input  logic                clk,
    input  pidl_pkg::cell_ctl_t ctl,
    input  logic signed [31:0]  ins_value,
    input  logic signed [31:0]  left,
    input  logic signed [31:0]  right,
    output logic signed [31:0]  entry,
    output logic signed [31:0]  tap
);
    import pidl_pkg::*;

    localparam logic [W-1:0] MY = W'(IDX);

    logic [W-1:0]       tgt;
    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic signed [31:0] tap_reg;
    logic signed [31:0] tap_next;

    assign tgt = W'(ctl.idx);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (MY == tgt)
                entry_next = ins_value;
            else if (MY > tgt)
                entry_next = left;
        end
        else if (ctl.del)
        begin
            if (MY >= tgt)
                entry_next = right;
        end
    end

    assign tap_next = (ctl.rd && (MY == tgt)) ? entry_reg : '0;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

// File: sim/tb_positional_insert_delete_list.sv
// self-checking testbench for the positional insert/delete list
module tb_positional_insert_delete_list;
    import pidl_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int SW          = $clog2(CAPACITY);
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_TAIL  = 150;

    // action codes the block does not define
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // shadow list plus the queue of responses still owed by the block
    class list_scoreboard;
        logic signed [31:0] slots [CAPACITY];
        int unsigned        occupancy = 0;
        rsp_t               owed [$];
        int unsigned        errors = 0;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_command(cmd_t c);
            rsp_t        r;
            int unsigned p;
            int          k;
            r.status = ST_OK;
            r.data   = '0;
            p        = 32'(c.position);
            case (c.action)
                ACT_READ:
                    if (p >= 1 && p <= occupancy) r.data = slots[SW'(p-1)];
                    else r.status = ST_BADPOS;
                ACT_INSERT:
                    if (p < 1 || p > occupancy + 1) r.status = ST_BADPOS;
                    else if (occupancy >= CAPACITY) r.status = ST_FULL;
                    else
                    begin
                        for (k = occupancy; k >= p; k--)
                            slots[SW'(k)] = slots[SW'(k-1)];
                        slots[SW'(p-1)] = c.value;
                        occupancy++;
                    end
                ACT_DELETE:
                    if (p < 1 || p > occupancy) r.status = ST_BADPOS;
                    else
                    begin
                        for (k = p; k < occupancy; k++)
                            slots[SW'(k-1)] = slots[SW'(k)];
                        occupancy--;
                    end
                ACT_CLEAR:
                    occupancy = 0;
                ACT_PRIOR:
                    if (p >= 2 && p <= occupancy) r.data = slots[SW'(p-2)];
                    else r.status = ST_BADPOS;
                ACT_NEXT:
                    if (p >= 1 && p < occupancy) r.data = slots[SW'(p)];
                    else r.status = ST_BADPOS;
                default:
                    r.status = ST_BADPOS;
            endcase
            r.count = occupancy[6:0];
            owed.push_back(r);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("result with no transaction pending: %p", got));
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.data !== want.data)
                report($sformatf("data %0d, want %0d", got.data, want.data));
            if (got.count !== want.count)
                report($sformatf("count %0d, want %0d", got.count, want.count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t command;
    logic done;
    rsp_t result;

    list_scoreboard sb = new;
    int             cycles = 0;

    positional_insert_delete_list #(.CAPACITY(CAPACITY)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // sample at the edge, before any driver update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(command);
            if (done)
                sb.check_result(result);
        end
    end

    task drive_cmd(input logic [2:0] act, input logic [6:0] pos,
                   input logic signed [31:0] val, input bit gaps);
        cmd_t c;
        c.action   = act;
        c.position = pos;
        c.value    = val;
        start   <= 1'b1;
        command <= c;
        do @(posedge clk); while (busy);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task run_random(int items);
        int               n;
        int               seg_left;
        int               mode;
        int               roll;
        int               ins_w;
        int               del_w;
        int               clr_w;
        int               lo;
        int               hi;
        logic [2:0]       act;
        logic [6:0]       pos;
        logic signed [31:0] val;
        // the first stretch grows the list so that it fills up early
        mode     = 0;
        seg_left = 250;
        for (n = 0; n < items; n++)
        begin
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(40, 160);
            end
            seg_left--;
            case (mode)
                0: begin ins_w = 70; del_w = 10; clr_w = 0; end
                1: begin ins_w = 10; del_w = 60; clr_w = 2; end
                default: begin ins_w = 35; del_w = 30; clr_w = 1; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < clr_w)
                act = ACT_CLEAR;
            else if (roll < clr_w + 2)
                act = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
            else if (roll < clr_w + 2 + ins_w)
                act = ACT_INSERT;
            else if (roll < clr_w + 2 + ins_w + del_w)
                act = ACT_DELETE;
            else
                case ($urandom_range(0, 2))
                    0: act = ACT_READ;
                    1: act = ACT_PRIOR;
                    default: act = ACT_NEXT;
                endcase

            lo = 1;
            hi = sb.occupancy;
            case (act)
                ACT_INSERT: hi = sb.occupancy + 1;
                ACT_PRIOR:  lo = 2;
                ACT_NEXT:   hi = sb.occupancy - 1;
                default:    ;
            endcase

            roll = $urandom_range(0, 9);
            if (hi >= lo && roll < 6)
                pos = 7'($urandom_range(lo, hi));
            else if (hi >= lo && roll < 8)
                pos = $urandom_range(0, 1) ? 7'(lo) : 7'(hi);
            else
                case ($urandom_range(0, 3))
                    0: pos = 7'(lo - 1);
                    1: pos = (hi + 1 > 127) ? 7'd127 : 7'(hi + 1);
                    2: pos = 7'd127;
                    default: pos = 7'($urandom_range(0, 127));
                endcase

            case ($urandom_range(0, 7))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                2: val = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
                default: val = $urandom;
            endcase

            drive_cmd(act, pos, val, n < items - QUIET_TAIL);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        command = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, bad positions, list edges, unused codes
        drive_cmd(ACT_CLEAR,    7'd0,   32'sd0,          1);
        drive_cmd(ACT_READ,     7'd1,   32'sd0,          1);
        drive_cmd(ACT_DELETE,   7'd1,   32'sd0,          1);
        drive_cmd(ACT_PRIOR,    7'd1,   32'sd0,          1);
        drive_cmd(ACT_NEXT,     7'd0,   32'sd0,          1);
        drive_cmd(ACT_INSERT,   7'd0,   32'sd5,          1);
        drive_cmd(ACT_INSERT,   7'd2,   32'sd5,          1);
        drive_cmd(ACT_INSERT,   7'd1,   32'sh7fff_ffff,  1);
        drive_cmd(ACT_INSERT,   7'd1,   32'sh8000_0000,  1);
        drive_cmd(ACT_INSERT,   7'd3,   -32'sd1,         1);
        drive_cmd(ACT_INSERT,   7'd2,   32'sd0,          1);
        drive_cmd(ACT_READ,     7'd1,   32'sd0,          1);
        drive_cmd(ACT_READ,     7'd4,   32'sd0,          1);
        drive_cmd(ACT_READ,     7'd5,   32'sd0,          1);
        drive_cmd(ACT_READ,     7'd0,   32'sd0,          1);
        drive_cmd(ACT_PRIOR,    7'd2,   32'sd0,          1);
        drive_cmd(ACT_PRIOR,    7'd1,   32'sd0,          1);
        drive_cmd(ACT_NEXT,     7'd3,   32'sd0,          1);
        drive_cmd(ACT_NEXT,     7'd4,   32'sd0,          1);
        drive_cmd(ACT_DELETE,   7'd2,   32'sd0,          1);
        drive_cmd(ACT_DELETE,   7'd4,   32'sd0,          1);
        drive_cmd(ACT_SPARE_LO, 7'd1,   32'sd9,          1);
        drive_cmd(ACT_SPARE_HI, 7'd127, -32'sd1,         1);
        drive_cmd(ACT_READ,     7'd127, 32'sd0,          1);
        drive_cmd(ACT_CLEAR,    7'd3,   32'sd0,          1);

        run_random(RANDOM_ITEMS);

        start <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/pidl_pkg.sv
design/pidl_cell.sv
design/positional_insert_delete_list.sv
sim/tb_positional_insert_delete_list.sv
